// ===== rtl/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the sorted set search and insert table.
// ----------------------------------------------------------------------------
package ssi_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int POS_W         = 4;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic compare_en;
      logic commit_en;
      logic insert_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

// ===== rtl/ssi_cell.sv =====
// ----------------------------------------------------------------------------
// ssi_cell
// One table slot: holds an entry, compares it with the key and takes the
// entry of its lower neighbor, or the key itself, when an insert shifts up.
// ----------------------------------------------------------------------------
module ssi_cell (
   input  logic                                  clock,
   input  ssi_pkg::cell_ctrl_type                ctrl,
   input  logic                                  valid,
   input  logic signed [ssi_pkg::DATA_W-1:0]     key,
   input  logic signed [ssi_pkg::DATA_W-1:0]     left_entry,
   input  logic                                  left_lt,
   output logic signed [ssi_pkg::DATA_W-1:0]     entry,
   output ssi_pkg::cell_flags_type               flags
);
   import ssi_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;
   cell_flags_type           flags_ff;
   cell_flags_type           flags_in;

   always_comb begin
      flags_in.lt = valid && (entry_ff < key);
      flags_in.eq = valid && (entry_ff == key);
   end

   // The first slot that is not below the key takes the key; every slot
   // above it takes its lower neighbor's entry.
   assign entry_in = left_lt ? key : left_entry;

   always_ff @(posedge clock) begin
      if (ctrl.compare_en) begin
         flags_ff <= flags_in;
      end
      if (ctrl.commit_en && ctrl.insert_en && !flags_ff.lt) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

// ===== rtl/ssi_index_enc.sv =====
// ----------------------------------------------------------------------------
// ssi_index_enc
// Turns a one-hot (or empty) slot vector into the slot index.
// ----------------------------------------------------------------------------
module ssi_index_enc #(
   parameter int DEPTH = ssi_pkg::DEPTH_DEFAULT,
   parameter int IDX_W = 4
) (
   input  logic [DEPTH-1:0] sel,
   output logic [IDX_W-1:0] idx
);
   import ssi_pkg::*;

   always_comb begin
      idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel[i]) begin
            idx = idx | IDX_W'(i);
         end
      end
   end

endmodule

// ===== rtl/sorted_set_search_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_set_search_insert
// Sorted table of distinct signed values with lookup and ordered insert.
// ----------------------------------------------------------------------------
// Each request word is looked up in a row of DEPTH slots kept in ascending
// order. A match returns its index with found set. An absent value is
// inserted before the first larger entry, the larger entries move up one
// slot, and the insertion index is returned. If the table is full, nothing
// is inserted, position is zero and full_res is set. One word is handled at
// a time and passes through the accept state, an evaluate state in which every
// slot compares its entry with the key and registers the outcome, and a
// commit state that shifts the slots and loads the response register. The
// commit state waits for as long as the response register still holds an
// unread word. The next request is taken while a response still waits to be
// read.
// ----------------------------------------------------------------------------
module sorted_set_search_insert #(
   parameter int DEPTH = ssi_pkg::DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [ssi_pkg::DATA_W-1:0]      req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [ssi_pkg::POS_W-1:0]              rsp_position,
   output logic                                   rsp_found,
   output logic                                   rsp_full_res,
   output logic [ssi_pkg::COUNT_OUT_W-1:0]        rsp_entry_count
);
   import ssi_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type                 state_ff;
   state_type                 state_in;
   cell_ctrl_type             ctrl;
   logic                      commit_go;

   logic signed [DATA_W-1:0]  key_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;

   logic signed [DATA_W-1:0]  entries [DEPTH];
   cell_flags_type            flags   [DEPTH];
   logic [DEPTH-1:0]          eq_vec;
   logic [DEPTH-1:0]          ins_vec;
   logic [DEPTH-1:0]          sel_vec;
   logic [IDX_W-1:0]          idx;

   logic                      any_found;
   logic                      is_full;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [POS_W-1:0]          position_ff;
   logic                      found_ff;
   logic                      full_ff;
   logic [COUNT_OUT_W-1:0]    entry_count_ff;
   logic [IDX_W+POS_W-1:0]    pos_wide;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE);
      ctrl.compare_en = (state_ff == ST_EVAL);
      ctrl.commit_en  = commit_go;
      ctrl.insert_en  = !any_found && !is_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff <= req_value;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     valid;
      logic signed [DATA_W-1:0] left_entry;
      logic                     left_lt;

      assign valid = (CNT_W'(i) < count_ff);
      if (i == 0) begin : g_first
         assign left_entry = key_ff;
         assign left_lt    = 1'b1;
      end else begin : g_rest
         assign left_entry = entries[i-1];
         assign left_lt    = flags[i-1].lt;
      end

      ssi_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (valid),
         .key        (key_ff),
         .left_entry (left_entry),
         .left_lt    (left_lt),
         .entry      (entries[i]),
         .flags      (flags[i])
      );

      assign eq_vec[i]  = flags[i].eq;
      assign ins_vec[i] = !flags[i].lt && left_lt;
   end

   assign any_found = |eq_vec;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign sel_vec   = any_found ? eq_vec : (is_full ? '0 : ins_vec);

   ssi_index_enc #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_enc (
      .sel (sel_vec),
      .idx (idx)
   );

   assign count_in   = (commit_go && ctrl.insert_en) ? count_ff + CNT_W'(1) : count_ff;
   assign pos_wide   = {{POS_W{1'b0}}, idx};
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_valid_in = commit_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_go) begin
         position_ff    <= pos_wide[POS_W-1:0];
         found_ff       <= any_found;
         full_ff        <= !any_found && is_full;
         entry_count_ff <= count_wide[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = position_ff;
   assign rsp_found       = found_ff;
   assign rsp_full_res    = full_ff;
   assign rsp_entry_count = entry_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the table depth.");

   a_single_match : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |-> $onehot0(eq_vec))
      else $error("More than one slot matches the key.");

   a_insert_slot : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && ctrl.insert_en) |-> $onehot(ins_vec))
      else $error("Insert without exactly one insertion slot.");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (commit_go && ctrl.insert_en) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Entry count did not advance on insert.");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(found_ff && full_ff))
      else $error("Response reports both found and full.");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted set search and insert table.
// ----------------------------------------------------------------------------
// A short directed sequence fills the table in scrambled order. It then hits
// the full and found cases and the extreme values. After that, random words
// look up stored values, their neighbors and fresh values. Every response
// word is compared field by field with a listed outcome from the directed
// table or with a local model of the sorted set. Both sides pause at random.
// Once, the receiver holds off for a long stretch, so the block backs up
// and stalls its input.
`timescale 1ns / 1ps

module testbench;

   localparam int TABLE_DEPTH = ssi_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_WORDS = 800;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [ssi_pkg::POS_W-1:0]       position;
      logic                            found;
      logic                            full_res;
      logic [ssi_pkg::COUNT_OUT_W-1:0] entry_count;
   } set_outcome_type;

   typedef struct packed {
      logic signed [ssi_pkg::DATA_W-1:0] value;
      logic                              has_literal;
      set_outcome_type                   outcome;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [ssi_pkg::DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ssi_pkg::POS_W-1:0] rsp_position;
   logic rsp_found;
   logic rsp_full_res;
   logic [ssi_pkg::COUNT_OUT_W-1:0] rsp_entry_count;

   logic signed [ssi_pkg::DATA_W-1:0] set_entries [TABLE_DEPTH];
   int unsigned set_size = 0;
   set_outcome_type pending_outcomes [$];
   int mismatch_count = 0;
   int words_checked = 0;
   int idle_cycles = 0;
   bit hold_done = 1'b0;

   directed_row_type directed_rows [22] = '{
      '{32'sd0,            1'b1, '{4'd0,  1'b0, 1'b0, 5'd1}},
      '{32'sd0,            1'b1, '{4'd0,  1'b1, 1'b0, 5'd1}},
      '{32'sh80000000,     1'b1, '{4'd0,  1'b0, 1'b0, 5'd2}},
      '{32'sh7FFFFFFF,     1'b1, '{4'd2,  1'b0, 1'b0, 5'd3}},
      '{-32'sd1,           1'b0, '0},
      '{32'sd100,          1'b0, '0},
      '{-32'sd100,         1'b0, '0},
      '{32'sd50,           1'b0, '0},
      '{32'sd7,            1'b0, '0},
      '{-32'sd7,           1'b0, '0},
      '{32'sd1000,         1'b0, '0},
      '{-32'sd1000,        1'b0, '0},
      '{32'sd3,            1'b0, '0},
      '{32'sd20,           1'b0, '0},
      '{-32'sd20,          1'b0, '0},
      '{32'sd200,          1'b0, '0},
      '{32'sd1,            1'b0, '0},
      '{32'sd5,            1'b1, '{4'd0,  1'b0, 1'b1, 5'd16}},
      '{32'sh7FFFFFFF,     1'b1, '{4'd15, 1'b1, 1'b0, 5'd16}},
      '{32'sh80000000,     1'b1, '{4'd0,  1'b1, 1'b0, 5'd16}},
      '{32'sd7,            1'b0, '0},
      '{32'sh80000001,     1'b1, '{4'd0,  1'b0, 1'b1, 5'd16}}
   };

   sorted_set_search_insert DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_found       (rsp_found),
      .rsp_full_res    (rsp_full_res),
      .rsp_entry_count (rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Looks the value up in the local sorted set and inserts it when absent.
   function automatic set_outcome_type predict_lookup_insert(
      input logic signed [ssi_pkg::DATA_W-1:0] value
   );
      set_outcome_type outcome;
      int unsigned slot;
      outcome = '0;
      for (int unsigned i = 0; i < set_size; i++) begin
         if (!outcome.found && set_entries[i] == value) begin
            outcome.found = 1'b1;
            outcome.position = i[ssi_pkg::POS_W-1:0];
         end
      end
      if (!outcome.found) begin
         if (set_size >= TABLE_DEPTH) begin
            outcome.full_res = 1'b1;
         end else begin
            slot = 0;
            while (slot < set_size && set_entries[slot] < value) begin
               slot++;
            end
            for (int unsigned j = set_size; j > slot; j--) begin
               set_entries[j] = set_entries[j - 1];
            end
            set_entries[slot] = value;
            set_size++;
            outcome.position = slot[ssi_pkg::POS_W-1:0];
         end
      end
      outcome.entry_count = set_size[ssi_pkg::COUNT_OUT_W-1:0];
      return outcome;
   endfunction

   function automatic int random_pause(input bit calm);
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(0, 19);
      if (roll < 13) begin
         return 0;
      end else if (roll < 19) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(
      input logic signed [ssi_pkg::DATA_W-1:0] value,
      input logic has_literal,
      input set_outcome_type literal,
      input bit calm
   );
      int pause;
      set_outcome_type predicted;
      pause = random_pause(calm);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      predicted = predict_lookup_insert(value);
      pending_outcomes.push_back(has_literal ? literal : predicted);
   endtask

   task automatic check_field(input string field, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                  expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      set_outcome_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         words_checked++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response word, position %0d found %0d full %0d count %0d",
                     $time, rsp_position, rsp_found, rsp_full_res, rsp_entry_count);
            mismatch_count++;
         end else begin
            expected = pending_outcomes.pop_front();
            check_field("position", int'(expected.position), int'(rsp_position));
            check_field("found", int'(expected.found), int'(rsp_found));
            check_field("full_res", int'(expected.full_res), int'(rsp_full_res));
            check_field("entry_count", int'(expected.entry_count),
                        int'(rsp_entry_count));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int pause;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && words_checked >= 200) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            pause = random_pause(words_checked >= 420 && words_checked < 560);
            if (pause > 0) begin
               rsp_ready <= 1'b0;
               repeat (pause) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      logic signed [ssi_pkg::DATA_W-1:0] value;
      int unsigned pick;
      int choice;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r]) begin
         send_word(directed_rows[r].value, directed_rows[r].has_literal,
                   directed_rows[r].outcome, 1'b0);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         choice = $urandom_range(0, 9);
         value = $urandom;
         if (set_size > 0 && choice < 7) begin
            pick = $urandom_range(0, set_size - 1);
            value = set_entries[pick];
            if (choice == 5) begin
               value = value + 1;
            end else if (choice == 6) begin
               value = value - 1;
            end
         end
         send_word(value, 1'b0, '0, n >= 400 && n < 550);
      end
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
